// File: design/sce_pkg.sv
`default_nettype none

package sce_pkg;

  // Widths of the value as it moves through the block.
  localparam int MagBits      = 64;
  localparam int ValBits      = 2 * MagBits;
  localparam int ExtBytes     = ValBits / 8 + 1;
  localparam int ExtBits      = ExtBytes * 8;
  localparam int LenBits      = 5;
  localparam int QueueDepth   = 2;
  localparam int QueuePtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QueueCntBits = $clog2(QueueDepth + 1);

  // Sign-extension bytes.
  localparam logic [7:0] PadNeg = 8'hff;
  localparam logic [7:0] PadPos = 8'h00;

  // Input word: sign flag and 128-bit magnitude.
  typedef struct packed {
    logic               negative;
    logic [MagBits-1:0] magnitude_high;
    logic [MagBits-1:0] magnitude_low;
  } item_t;

  // Output word: one encoded byte.
  typedef struct packed {
    logic [7:0]         byte_value;
    logic               last_byte;
    logic [LenBits-1:0] total_length;
  } code_t;

  // Queue entry: encoding aligned so its first byte sits at the top, plus its length.
  typedef struct packed {
    logic [ExtBits-1:0] data;
    logic [LenBits-1:0] len;
  } entry_t;

endpackage

`default_nettype wire

// File: design/sce_front.sv
`default_nettype none

module sce_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire sce_pkg::item_t item,
  input  wire logic           item_valid,
  output logic                item_stall,
  output logic                push,
  output sce_pkg::entry_t     push_entry,
  input  wire logic           full
);

  // Stage 1: for a negative value, low word negated, high word inverted, carry pending.
  logic                        s1_valid;
  logic                        s1_neg;
  logic                        s1_carry;
  logic [sce_pkg::MagBits-1:0] s1_hi;
  logic [sce_pkg::MagBits-1:0] s1_lo;

  // Stage 2: full two's complement value and its pad byte.
  logic                        s2_valid;
  logic [7:0]                  s2_pad;
  logic [sce_pkg::ValBits-1:0] s2_val;

  // Stage 3: sign-extended value and encoding length.
  logic                        s3_valid;
  logic [sce_pkg::ExtBits-1:0] s3_ext;
  logic [sce_pkg::LenBits-1:0] s3_len;

  logic s1_ready;
  logic s2_ready;
  logic s3_ready;

  logic                        in_zero;
  logic                        in_neg;
  logic [sce_pkg::LenBits-1:0] len_next;
  logic [sce_pkg::LenBits-1:0] shamt;

  // Each stage moves when it is empty or the one after it moves.
  assign s3_ready   = !s3_valid || !full;
  assign s2_ready   = !s2_valid || s3_ready;
  assign s1_ready   = !s1_valid || s2_ready;
  assign item_stall = !s1_ready;

  // A zero magnitude is always positive.
  assign in_zero = (item.magnitude_high == '0) && (item.magnitude_low == '0);
  assign in_neg  = item.negative && !in_zero;

  // Find the first byte below the pad that differs from it; add a lead byte
  // when its top bit would misstate the sign.
  always_comb begin
    logic [7:0] b;
    len_next = sce_pkg::LenBits'(1);
    for (int k = sce_pkg::ExtBytes - 1; k >= 1; k--) begin
      b = s2_val[(sce_pkg::ExtBytes - 1 - k) * 8 +: 8];
      if (b != s2_pad) begin
        len_next = sce_pkg::LenBits'(sce_pkg::ExtBytes - k)
                 + sce_pkg::LenBits'(b[7] != s2_pad[7]);
      end
    end
  end

  // Align the encoding so its first byte is at the top of the entry.
  assign shamt            = sce_pkg::LenBits'(sce_pkg::ExtBytes) - s3_len;
  assign push             = s3_valid && !full;
  assign push_entry.data  = s3_ext << {shamt, 3'b000};
  assign push_entry.len   = s3_len;

  // Pipeline registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= item_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (s3_ready) begin
        s3_valid <= s2_valid;
      end
    end
    if (s1_ready && item_valid) begin
      s1_neg   <= in_neg;
      s1_carry <= in_neg && (item.magnitude_low == '0);
      s1_hi    <= in_neg ? ~item.magnitude_high : item.magnitude_high;
      s1_lo    <= in_neg ? (~item.magnitude_low + 1'b1) : item.magnitude_low;
    end
    if (s2_ready && s1_valid) begin
      s2_pad <= s1_neg ? sce_pkg::PadNeg : sce_pkg::PadPos;
      s2_val <= {s1_hi + sce_pkg::MagBits'(s1_carry), s1_lo};
    end
    if (s3_ready && s2_valid) begin
      s3_ext <= {s2_pad, s2_val};
      s3_len <= len_next;
    end
  end

endmodule

`default_nettype wire

// File: design/sce_queue.sv
`default_nettype none

module sce_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire sce_pkg::entry_t push_entry,
  output logic                 full,
  input  wire logic            pop,
  output logic                 pop_valid,
  output sce_pkg::entry_t      pop_entry
);

  sce_pkg::entry_t                  mem [sce_pkg::QueueDepth];
  logic [sce_pkg::QueuePtrBits-1:0] wr_ptr;
  logic [sce_pkg::QueuePtrBits-1:0] rd_ptr;
  logic [sce_pkg::QueueCntBits-1:0] count;

  assign full      = (count == sce_pkg::QueueCntBits'(sce_pkg::QueueDepth));
  assign pop_valid = (count != '0);
  assign pop_entry = mem[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == sce_pkg::QueuePtrBits'(sce_pkg::QueueDepth - 1))
                ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == sce_pkg::QueuePtrBits'(sce_pkg::QueueDepth - 1))
                ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// File: design/sce_back.sv
`default_nettype none

module sce_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            pop_valid,
  input  wire sce_pkg::entry_t pop_entry,
  output logic                 pop,
  output sce_pkg::code_t       code,
  output logic                 code_valid,
  input  wire logic            code_stall
);

  logic [sce_pkg::ExtBits-1:0] data;
  logic [sce_pkg::LenBits-1:0] remain;
  logic [sce_pkg::LenBits-1:0] len;
  logic                        take;
  logic                        at_last;

  assign at_last = (remain == sce_pkg::LenBits'(1));
  assign take    = code_valid && !code_stall;

  // Load the next entry when the output is empty or its last byte leaves.
  assign pop = pop_valid && (!code_valid || (take && at_last));

  assign code.byte_value   = data[sce_pkg::ExtBits-1 -: 8];
  assign code.last_byte    = at_last;
  assign code.total_length = len;

  // Byte shifter and output word.
  always_ff @(posedge clk) begin
    if (rst) begin
      code_valid <= 1'b0;
    end else if (pop) begin
      code_valid <= 1'b1;
    end else if (take && at_last) begin
      code_valid <= 1'b0;
    end
    if (pop) begin
      data   <= pop_entry.data;
      remain <= pop_entry.len;
      len    <= pop_entry.len;
    end else if (take && !at_last) begin
      data   <= {data[sce_pkg::ExtBits-9:0], 8'h00};
      remain <= remain - 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: design/signed_coefficient_byte_encoder.sv
// Encodes a sign flag and a 128-bit magnitude as the shortest big-endian
// two's complement byte string (1 to 17 bytes) and emits it one byte per
// cycle while code_stall is low, most significant byte first, with last_byte
// on the final byte and total_length on every byte. A zero magnitude always
// encodes as one 0x00 byte. A value holds the output until all of its bytes
// have left, so the sustained rate is set by the byte shifter at the output;
// a new value is taken every cycle as long as that shifter keeps up. A value
// passes the front stages, the queue and the output register before it shows,
// and a two-word queue lets the input keep working while the output is stalled.
`default_nettype none

module signed_coefficient_byte_encoder (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire sce_pkg::item_t item,
  input  wire logic           item_valid,
  output logic                item_stall,
  output sce_pkg::code_t      code,
  output logic                code_valid,
  input  wire logic           code_stall
);

  logic            push;
  logic            full;
  logic            pop;
  logic            pop_valid;
  sce_pkg::entry_t push_entry;
  sce_pkg::entry_t pop_entry;

  // Negation, length and alignment.
  sce_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .push       (push),
    .push_entry (push_entry),
    .full       (full)
  );

  // Queue between the two halves.
  sce_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry)
  );

  // Byte output.
  sce_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry),
    .pop        (pop),
    .code       (code),
    .code_valid (code_valid),
    .code_stall (code_stall)
  );

  // A byte that is not the last one is always followed by the next byte.
  assert property (@(posedge clk) disable iff (rst)
    code_valid && !code_stall && !code.last_byte |=> code_valid)
    else $error("encoding cut short");

  // Every byte carries a length in range.
  assert property (@(posedge clk) disable iff (rst)
    code_valid |-> (code.total_length >= 5'd1) && (code.total_length <= 5'd17))
    else $error("length out of range");

  // A single-byte encoding is marked last on its only byte.
  assert property (@(posedge clk) disable iff (rst)
    code_valid && (code.total_length == 5'd1) |-> code.last_byte)
    else $error("single byte not marked last");

  // The queue is never popped empty.
  assert property (@(posedge clk) disable iff (rst)
    pop |-> pop_valid)
    else $error("queue popped while empty");

endmodule

`default_nettype wire

// File: tb/signed_coefficient_byte_encoder_test.sv
`timescale 1ns / 1ps

module signed_coefficient_byte_encoder_test;

  localparam int QuietLimit = 3000;
  localparam int HoldCycles = 250;
  localparam int DrainCycles = 10;

  // Keeps the expected byte strings in arrival order and checks each output word.
  class byte_string_board;
    sce_pkg::code_t expected_bytes[$];
    int unsigned failures;

    function new();
      failures = 0;
    endfunction

    // Encode one accepted value into its minimal two's complement byte string.
    function void add_value(sce_pkg::item_t it);
      logic [sce_pkg::ValBits-1:0] mag;
      logic [sce_pkg::ValBits-1:0] val;
      logic [sce_pkg::ExtBits-1:0] ext;
      logic [7:0] pad;
      logic neg;
      int first;
      int len;
      int pos;
      int k;
      sce_pkg::code_t c;
      mag = {it.magnitude_high, it.magnitude_low};
      // A zero magnitude is always positive zero.
      neg = it.negative && (mag != '0);
      val = neg ? (~mag + 1'b1) : mag;
      pad = neg ? sce_pkg::PadNeg : sce_pkg::PadPos;
      ext = {pad, val};
      first = sce_pkg::ExtBytes;
      for (k = 1; k < sce_pkg::ExtBytes; k++) begin
        if (first == sce_pkg::ExtBytes && ext[(sce_pkg::ExtBytes - 1 - k) * 8 +: 8] != pad)
          first = k;
      end
      if (first == sce_pkg::ExtBytes) begin
        len = 1;
      end else begin
        len = sce_pkg::ExtBytes - first;
        // Add a lead byte when the top bit would misstate the sign.
        if (ext[(sce_pkg::ExtBytes - 1 - first) * 8 + 7] != pad[7]) len++;
      end
      for (k = 0; k < len; k++) begin
        pos = sce_pkg::ExtBytes - len + k;
        c.byte_value = ext[(sce_pkg::ExtBytes - 1 - pos) * 8 +: 8];
        c.last_byte = (k == len - 1);
        c.total_length = sce_pkg::LenBits'(len);
        expected_bytes.push_back(c);
      end
    endfunction

    // Compare one output word with the oldest expected byte.
    function void check_byte(sce_pkg::code_t got);
      sce_pkg::code_t want;
      if (expected_bytes.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected word: byte %h last %b length %0d",
                   got.byte_value, got.last_byte, got.total_length);
        return;
      end
      want = expected_bytes.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: expected byte %h last %b length %0d, got byte %h last %b length %0d",
                   want.byte_value, want.last_byte, want.total_length,
                   got.byte_value, got.last_byte, got.total_length);
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  sce_pkg::item_t item = '0;
  logic item_valid = 1'b0;
  logic item_stall;
  sce_pkg::code_t code;
  logic code_valid;
  logic code_stall = 1'b0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  byte_string_board board = new();

  signed_coefficient_byte_encoder dut (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .code       (code),
    .code_valid (code_valid),
    .code_stall (code_stall)
  );

  always #5 clk = ~clk;

  // Receiver: long hold-off when requested, otherwise random stalls.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      code_stall <= 1'b1;
      hold_left--;
    end else begin
      code_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watch both channels at the rising edge.
  always @(posedge clk) begin
    if (!rst && item_valid && !item_stall) board.add_value(item);
    if (!rst && code_valid && !code_stall) board.check_byte(code);
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (code_valid && !code_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic sce_pkg::item_t make_item(logic neg, logic [sce_pkg::MagBits-1:0] hi,
                                               logic [sce_pkg::MagBits-1:0] lo);
    sce_pkg::item_t it;
    it.negative = neg;
    it.magnitude_high = hi;
    it.magnitude_low = lo;
    return it;
  endfunction

  // Random values with sizes spread over every byte length and lead-byte boundary.
  function automatic sce_pkg::item_t random_value();
    logic [sce_pkg::ValBits-1:0] mag;
    logic [sce_pkg::ValBits-1:0] one_bit;
    int nbits;
    mag = {$urandom, $urandom, $urandom, $urandom};
    nbits = $urandom_range(sce_pkg::ValBits - 1);
    one_bit = {{(sce_pkg::ValBits - 1){1'b0}}, 1'b1} << nbits;
    case ($urandom_range(9))
      0: mag = one_bit;
      1: mag = one_bit - 1'b1;
      2: mag = (one_bit - 1'b1) | one_bit;
      3, 4: ;
      default: mag = mag & ((one_bit << 1) - 1'b1);
    endcase
    return make_item(1'($urandom_range(1)), mag[sce_pkg::ValBits-1:sce_pkg::MagBits],
                     mag[sce_pkg::MagBits-1:0]);
  endfunction

  // Offer one word and hold it until the block takes it.
  task automatic send_item(input sce_pkg::item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
  endtask

  // Stop offering and wait for every expected byte.
  task automatic wait_drained();
    item_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
  endtask

  task automatic random_phase(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_item(random_value());
    wait_drained();
  endtask

  initial begin
    sce_pkg::item_t directed[$];
    directed.push_back(make_item(1'b0, '0, '0));
    directed.push_back(make_item(1'b1, '0, '0));
    directed.push_back(make_item(1'b0, '0, 64'd1));
    directed.push_back(make_item(1'b1, '0, 64'd1));
    directed.push_back(make_item(1'b0, '0, 64'h7f));
    directed.push_back(make_item(1'b0, '0, 64'h80));
    directed.push_back(make_item(1'b1, '0, 64'h80));
    directed.push_back(make_item(1'b1, '0, 64'h81));
    directed.push_back(make_item(1'b0, '0, 64'hff));
    directed.push_back(make_item(1'b1, '0, 64'hff));
    directed.push_back(make_item(1'b0, '1, '1));
    directed.push_back(make_item(1'b1, '1, '1));
    directed.push_back(make_item(1'b0, 64'h8000_0000_0000_0000, '0));
    directed.push_back(make_item(1'b1, 64'h8000_0000_0000_0000, '0));
    directed.push_back(make_item(1'b1, 64'd1, '0));
    directed.push_back(make_item(1'b0, '0, '1));
    directed.push_back(make_item(1'b1, '0, '1));
    directed.push_back(make_item(1'b1, '1, '0));
    directed.push_back(make_item(1'b0, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa));
    directed.push_back(make_item(1'b1, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555));
    directed.push_back(make_item(1'b0, '0, 64'h8000_0000_0000_0000));
    directed.push_back(make_item(1'b1, '0, 64'h8000_0000_0000_0000));

    // Synchronous reset at the start.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed corners with no idling.
    foreach (directed[i]) send_item(directed[i]);
    wait_drained();

    random_phase(40, 0, 0);
    random_phase(40, 82, 0);
    random_phase(40, 0, 82);
    random_phase(40, 20, 20);

    // Back-to-back values while the receiver holds off, to fill the block.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = HoldCycles;
    repeat (16) send_item(random_value());
    wait_drained();

    repeat (DrainCycles) @(negedge clk);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/sce_pkg.sv
design/sce_front.sv
design/sce_queue.sv
design/sce_back.sv
design/signed_coefficient_byte_encoder.sv
tb/signed_coefficient_byte_encoder_test.sv
